// ===== rtl/ppc_pkg.sv =====
`default_nettype none

package ppc_pkg;

    localparam int unsigned NUM_CLASSES = 9;
    localparam int unsigned CLS_W = 4;
    localparam int unsigned LEN_W = 16;
    localparam int unsigned OUT_W = 64;

    localparam logic [CLS_W-1:0] CLS_IPV4      = 4'd0;
    localparam logic [CLS_W-1:0] CLS_IPV6      = 4'd1;
    localparam logic [CLS_W-1:0] CLS_ARP       = 4'd2;
    localparam logic [CLS_W-1:0] CLS_OTHER_ETH = 4'd3;
    localparam logic [CLS_W-1:0] CLS_ICMPV4    = 4'd4;
    localparam logic [CLS_W-1:0] CLS_ICMPV6    = 4'd5;
    localparam logic [CLS_W-1:0] CLS_TCP       = 4'd6;
    localparam logic [CLS_W-1:0] CLS_UDP       = 4'd7;
    localparam logic [CLS_W-1:0] CLS_OTHER_IP  = 4'd8;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
    localparam logic [15:0] ETYPE_ARP  = 16'h0806;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic [LEN_W-1:0] ETH_HDR_BYTES      = 16'd14;
    localparam logic [LEN_W-1:0] ETH_IPV4_HDR_BYTES = 16'd34;

    typedef enum logic [2:0] {
        ETH_IPV4  = 3'd0,
        ETH_IPV6  = 3'd1,
        ETH_ARP   = 3'd2,
        ETH_OTHER = 3'd3,
        ETH_TRUNC = 3'd4,
        ETH_NONE  = 3'd5
    } eth_class_t;

    typedef enum logic [2:0] {
        IP_ICMP  = 3'd0,
        IP_TCP   = 3'd1,
        IP_UDP   = 3'd2,
        IP_OTHER = 3'd3,
        IP_NONE  = 3'd4
    } ip_class_t;

    typedef enum logic {
        FUNC_PACKET = 1'b0,
        FUNC_READ   = 1'b1
    } func_t;

    typedef struct packed {
        func_t            func;
        logic [LEN_W-1:0] captured_len;
        logic [15:0]      ethertype;
        logic [3:0]       ip_header_words;
        logic [LEN_W-1:0] ip_len_bytes;
        logic [7:0]       ip_protocol;
        logic [CLS_W-1:0] read_class;
    } item_t;

    typedef struct packed {
        logic                   is_read;
        logic [CLS_W-1:0]       rd_class;
        logic                   err_inc;
        logic [NUM_CLASSES-1:0] inc;
        logic [LEN_W-1:0]       payload;
        logic [LEN_W-1:0]       total;
        eth_class_t             ether_class;
        ip_class_t              ip_class;
    } upd_t;

endpackage

`default_nettype wire

// ===== rtl/packet_protocol_counter.sv =====
`default_nettype none
// m_tvalid rises once its item has passed from the input register into the result
// register, and the result is held there until m_tready takes it.
// Throughput: one item per cycle unless m_tready stalls the result register; each
// counter takes one add per item, as the item moves from the input to the result register.
// Reset: synchronous active-low aresetn clears all class counters, the error
// count and both stage valids.

module packet_protocol_counter #(
    parameter int unsigned COUNTER_WIDTH = 64
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // captured_len, ethertype, ip_header_words, ip_len_bytes, ip_protocol, read_class
    input  wire logic [63:0]  s_tdata,
    // func
    input  wire logic [0:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // read_packets, read_payload, read_total, read_errors
    output logic [255:0]      m_tdata,
    // ether_class, ip_class
    output logic [5:0]        m_tuser
);

    ppc_pkg::item_t s_item;
    ppc_pkg::item_t item;
    ppc_pkg::upd_t  upd;
    logic           item_valid;
    logic           advance;
    logic           upd_en;

    logic [COUNTER_WIDTH-1:0] rd_packets;
    logic [COUNTER_WIDTH-1:0] rd_payload;
    logic [COUNTER_WIDTH-1:0] rd_total;
    logic [COUNTER_WIDTH-1:0] rd_errors;

    logic                     m_valid_reg;
    logic                     m_valid_next;
    ppc_pkg::eth_class_t      eth_reg;
    ppc_pkg::ip_class_t       ip_reg;
    logic [COUNTER_WIDTH-1:0] packets_reg;
    logic [COUNTER_WIDTH-1:0] payload_reg;
    logic [COUNTER_WIDTH-1:0] total_reg;
    logic [COUNTER_WIDTH-1:0] errors_reg;

    assign s_item.func            = ppc_pkg::func_t'(s_tuser[0]);
    assign s_item.captured_len    = s_tdata[15:0];
    assign s_item.ethertype       = s_tdata[31:16];
    assign s_item.ip_header_words = s_tdata[35:32];
    assign s_item.ip_len_bytes    = s_tdata[51:36];
    assign s_item.ip_protocol     = s_tdata[59:52];
    assign s_item.read_class      = s_tdata[63:60];

    assign advance = !m_valid_reg || m_tready;
    assign upd_en  = advance && item_valid;

    ppc_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ppc_classify u_classify (
        .item (item),
        .upd  (upd)
    );

    ppc_counters #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_counters (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .upd_en     (upd_en),
        .upd        (upd),
        .rd_packets (rd_packets),
        .rd_payload (rd_payload),
        .rd_total   (rd_total),
        .rd_errors  (rd_errors)
    );

    assign m_valid_next = advance ? item_valid : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (upd_en) begin
            eth_reg     <= upd.ether_class;
            ip_reg      <= upd.ip_class;
            packets_reg <= rd_packets;
            payload_reg <= rd_payload;
            total_reg   <= rd_total;
            errors_reg  <= rd_errors;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = {ip_reg, eth_reg};
    assign m_tdata  = {ppc_pkg::OUT_W'(errors_reg), ppc_pkg::OUT_W'(total_reg),
                       ppc_pkg::OUT_W'(payload_reg), ppc_pkg::OUT_W'(packets_reg)};

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty result register");

endmodule

`default_nettype wire

// ===== rtl/ppc_in_stage.sv =====
`default_nettype none

module ppc_in_stage (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire ppc_pkg::item_t s_item,
    input  wire logic          advance,
    output logic               item_valid,
    output ppc_pkg::item_t     item
);

    logic           valid_reg;
    logic           valid_next;
    ppc_pkg::item_t item_reg;
    logic           s_fire;

    assign s_tready   = !valid_reg || advance;
    assign s_fire     = s_tvalid && s_tready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        if (s_fire) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg <= s_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ppc_classify.sv =====
`default_nettype none

module ppc_classify (
    input  wire ppc_pkg::item_t item,
    output ppc_pkg::upd_t       upd
);

    logic [5:0]                hdr_bytes;
    logic [ppc_pkg::LEN_W-1:0] hdr_bytes_ext;
    logic                      is_ipv4;
    logic                      short_cap;

    assign hdr_bytes     = {item.ip_header_words, 2'b00};
    assign hdr_bytes_ext = ppc_pkg::LEN_W'(hdr_bytes);
    assign is_ipv4       = item.ethertype == ppc_pkg::ETYPE_IPV4;
    assign short_cap     = (item.captured_len < ppc_pkg::ETH_HDR_BYTES) ||
                           (is_ipv4 && item.captured_len < ppc_pkg::ETH_IPV4_HDR_BYTES);

    always_comb begin
        upd             = '0;
        upd.rd_class    = item.read_class;
        upd.ether_class = ppc_pkg::ETH_NONE;
        upd.ip_class    = ppc_pkg::IP_NONE;
        upd.total       = item.ip_len_bytes;
        if (item.ip_len_bytes > hdr_bytes_ext) begin
            upd.payload = item.ip_len_bytes - hdr_bytes_ext;
        end else begin
            upd.payload = '0;
        end
        if (item.func == ppc_pkg::FUNC_READ) begin
            upd.is_read = 1'b1;
        end else if (short_cap) begin
            upd.err_inc     = 1'b1;
            upd.ether_class = ppc_pkg::ETH_TRUNC;
        end else if (is_ipv4) begin
            upd.inc[ppc_pkg::CLS_IPV4] = 1'b1;
            upd.ether_class            = ppc_pkg::ETH_IPV4;
            case (item.ip_protocol)
                ppc_pkg::PROTO_ICMP: begin
                    upd.inc[ppc_pkg::CLS_ICMPV4] = 1'b1;
                    upd.ip_class                 = ppc_pkg::IP_ICMP;
                end
                ppc_pkg::PROTO_TCP: begin
                    upd.inc[ppc_pkg::CLS_TCP] = 1'b1;
                    upd.ip_class              = ppc_pkg::IP_TCP;
                end
                ppc_pkg::PROTO_UDP: begin
                    upd.inc[ppc_pkg::CLS_UDP] = 1'b1;
                    upd.ip_class              = ppc_pkg::IP_UDP;
                end
                default: begin
                    upd.inc[ppc_pkg::CLS_OTHER_IP] = 1'b1;
                    upd.ip_class                   = ppc_pkg::IP_OTHER;
                end
            endcase
        end else if (item.ethertype == ppc_pkg::ETYPE_IPV6) begin
            upd.inc[ppc_pkg::CLS_IPV6] = 1'b1;
            upd.ether_class            = ppc_pkg::ETH_IPV6;
        end else if (item.ethertype == ppc_pkg::ETYPE_ARP) begin
            upd.inc[ppc_pkg::CLS_ARP] = 1'b1;
            upd.ether_class           = ppc_pkg::ETH_ARP;
        end else begin
            upd.inc[ppc_pkg::CLS_OTHER_ETH] = 1'b1;
            upd.ether_class                 = ppc_pkg::ETH_OTHER;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ppc_counters.sv =====
`default_nettype none

module ppc_counters #(
    parameter int unsigned COUNTER_WIDTH = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               upd_en,
    input  wire ppc_pkg::upd_t      upd,
    output logic [COUNTER_WIDTH-1:0] rd_packets,
    output logic [COUNTER_WIDTH-1:0] rd_payload,
    output logic [COUNTER_WIDTH-1:0] rd_total,
    output logic [COUNTER_WIDTH-1:0] rd_errors
);

    localparam int unsigned NCLS = ppc_pkg::NUM_CLASSES;

    // only the ipv4 class ever accumulates bytes; reads of the other classes return zero byte counts
    logic [COUNTER_WIDTH-1:0] pkt_reg [NCLS];
    logic [COUNTER_WIDTH-1:0] pkt_next [NCLS];
    logic [COUNTER_WIDTH-1:0] pl_reg;
    logic [COUNTER_WIDTH-1:0] pl_next;
    logic [COUNTER_WIDTH-1:0] tot_reg;
    logic [COUNTER_WIDTH-1:0] tot_next;
    logic [COUNTER_WIDTH-1:0] err_reg;
    logic [COUNTER_WIDTH-1:0] err_next;
    logic                     ipv4_en;

    assign ipv4_en = upd_en && upd.inc[ppc_pkg::CLS_IPV4];

    always_comb begin
        for (int i = 0; i < NCLS; i++) begin
            pkt_next[i] = pkt_reg[i] +
                          COUNTER_WIDTH'(upd_en && upd.inc[i]);
        end
        pl_next  = ipv4_en ? pl_reg + COUNTER_WIDTH'(upd.payload) : pl_reg;
        tot_next = ipv4_en ? tot_reg + COUNTER_WIDTH'(upd.total) : tot_reg;
        err_next = err_reg + COUNTER_WIDTH'(upd_en && upd.err_inc);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NCLS; i++) begin
                pkt_reg[i] <= '0;
            end
            pl_reg  <= '0;
            tot_reg <= '0;
            err_reg <= '0;
        end else begin
            for (int i = 0; i < NCLS; i++) begin
                pkt_reg[i] <= pkt_next[i];
            end
            pl_reg  <= pl_next;
            tot_reg <= tot_next;
            err_reg <= err_next;
        end
    end

    always_comb begin
        rd_packets = '0;
        rd_payload = '0;
        rd_total   = '0;
        if (upd.is_read && upd.rd_class < ppc_pkg::CLS_W'(NCLS)) begin
            rd_packets = pkt_reg[upd.rd_class];
            if (upd.rd_class == ppc_pkg::CLS_IPV4) begin
                rd_payload = pl_reg;
                rd_total   = tot_reg;
            end
        end
        rd_errors = err_next;
    end

    a_err_step: assert property (@(posedge aclk) disable iff (!aresetn)
        upd_en && upd.err_inc |=> err_reg == $past(err_reg) + COUNTER_WIDTH'(1))
        else $error("error count did not advance by one");

    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !upd_en |=> $stable(err_reg) && $stable(pl_reg) && $stable(tot_reg) &&
                    $stable(pkt_reg[ppc_pkg::CLS_IPV4]))
        else $error("counters changed without an item");

    a_icmpv6_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        pkt_reg[ppc_pkg::CLS_ICMPV6] == '0)
        else $error("icmpv6 class counted");

    a_inc_count: assert property (@(posedge aclk) disable iff (!aresetn)
        upd_en |-> $countones(upd.inc) <= 2 && !(upd.err_inc && upd.inc != '0))
        else $error("inconsistent class increments");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
module tb_top;
    import ppc_pkg::*;

    localparam int unsigned IDLE_PCT = 14;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned RANDOM_ITEMS = 1000;
    localparam int unsigned CALM_START = 1200;
    localparam int unsigned CALM_END = 1800;
    localparam logic [CLS_W-1:0] CLS_FIRST_UNUSED = CLS_W'(NUM_CLASSES);
    localparam logic [CLS_W-1:0] CLS_LAST_CODE = '1;

    typedef struct {
        eth_class_t  eth;
        ip_class_t   ip;
        logic [63:0] packets;
        logic [63:0] payload;
        logic [63:0] total;
        logic [63:0] errors;
    } stats_t;

    logic         aclk;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [63:0]  s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [255:0] m_tdata;
    logic [5:0]   m_tuser;

    item_t       pending_items[$];
    stats_t      expected_stats[$];
    logic [63:0] pkt_count[NUM_CLASSES];
    logic [63:0] payload_count[NUM_CLASSES];
    logic [63:0] byte_count[NUM_CLASSES];
    logic [63:0] trunc_count;
    int unsigned cycle_count = 0;
    int unsigned stall_cycles = 0;
    int unsigned failures = 0;
    logic        calm;

    packet_protocol_counter u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    assign calm = (cycle_count >= CALM_START) && (cycle_count < CALM_END);

    function automatic item_t make_item(func_t f, logic [15:0] cap, logic [15:0] etype,
                                        logic [3:0] hw, logic [15:0] tlen,
                                        logic [7:0] proto, logic [CLS_W-1:0] rcls);
        item_t it;
        it.func            = f;
        it.captured_len    = cap;
        it.ethertype       = etype;
        it.ip_header_words = hw;
        it.ip_len_bytes    = tlen;
        it.ip_protocol     = proto;
        it.read_class      = rcls;
        return it;
    endfunction

    function automatic item_t random_packet();
        int unsigned pick;
        logic [15:0] etype;
        logic [15:0] cap;
        logic [15:0] tlen;
        logic [7:0]  proto;
        pick = $urandom_range(99);
        if (pick < 50) etype = ETYPE_IPV4;
        else if (pick < 60) etype = ETYPE_IPV6;
        else if (pick < 70) etype = ETYPE_ARP;
        else etype = 16'($urandom_range(16'hFFFF));
        pick = $urandom_range(9);
        if (pick == 0) cap = 16'($urandom_range(ETH_HDR_BYTES - 1));
        else if (pick == 1) cap = 16'($urandom_range(ETH_IPV4_HDR_BYTES - 1, ETH_HDR_BYTES));
        else cap = 16'($urandom_range(16'hFFFF, ETH_IPV4_HDR_BYTES));
        tlen = ($urandom_range(1) == 0) ? 16'($urandom_range(16'hFFFF))
                                         : 16'($urandom_range(80));
        case ($urandom_range(3))
            0: proto = PROTO_ICMP;
            1: proto = PROTO_TCP;
            2: proto = PROTO_UDP;
            default: proto = 8'($urandom_range(8'hFF));
        endcase
        return make_item(FUNC_PACKET, cap, etype, 4'($urandom_range(15)), tlen, proto,
                         CLS_W'($urandom_range(CLS_LAST_CODE)));
    endfunction

    function automatic item_t random_read();
        logic [CLS_W-1:0] rcls;
        if ($urandom_range(99) < 80) rcls = CLS_W'($urandom_range(CLS_OTHER_IP));
        else rcls = CLS_W'($urandom_range(CLS_LAST_CODE, CLS_FIRST_UNUSED));
        return make_item(FUNC_READ, 16'($urandom_range(16'hFFFF)),
                         16'($urandom_range(16'hFFFF)), 4'($urandom_range(15)),
                         16'($urandom_range(16'hFFFF)), 8'($urandom_range(8'hFF)), rcls);
    endfunction

    function automatic void tally(logic [CLS_W-1:0] cls, logic [15:0] pay, logic [15:0] tot);
        pkt_count[cls]     = pkt_count[cls] + 64'd1;
        payload_count[cls] = payload_count[cls] + 64'(pay);
        byte_count[cls]    = byte_count[cls] + 64'(tot);
    endfunction

    function automatic stats_t count_packet(item_t it);
        stats_t      r;
        logic [15:0] hdr_bytes;
        r.eth     = ETH_NONE;
        r.ip      = IP_NONE;
        r.packets = '0;
        r.payload = '0;
        r.total   = '0;
        if (it.func == FUNC_READ) begin
            if (it.read_class < NUM_CLASSES) begin
                r.packets = pkt_count[it.read_class];
                r.payload = payload_count[it.read_class];
                r.total   = byte_count[it.read_class];
            end
        end else if (it.captured_len < ETH_HDR_BYTES ||
                     (it.ethertype == ETYPE_IPV4 && it.captured_len < ETH_IPV4_HDR_BYTES)) begin
            trunc_count = trunc_count + 64'd1;
            r.eth = ETH_TRUNC;
        end else if (it.ethertype == ETYPE_IPV4) begin
            hdr_bytes = {10'd0, it.ip_header_words, 2'b00};
            tally(CLS_IPV4, (it.ip_len_bytes > hdr_bytes) ? it.ip_len_bytes - hdr_bytes : '0,
                  it.ip_len_bytes);
            r.eth = ETH_IPV4;
            case (it.ip_protocol)
                PROTO_ICMP: begin
                    tally(CLS_ICMPV4, '0, '0);
                    r.ip = IP_ICMP;
                end
                PROTO_TCP: begin
                    tally(CLS_TCP, '0, '0);
                    r.ip = IP_TCP;
                end
                PROTO_UDP: begin
                    tally(CLS_UDP, '0, '0);
                    r.ip = IP_UDP;
                end
                default: begin
                    tally(CLS_OTHER_IP, '0, '0);
                    r.ip = IP_OTHER;
                end
            endcase
        end else if (it.ethertype == ETYPE_IPV6) begin
            tally(CLS_IPV6, '0, '0);
            r.eth = ETH_IPV6;
        end else if (it.ethertype == ETYPE_ARP) begin
            tally(CLS_ARP, '0, '0);
            r.eth = ETH_ARP;
        end else begin
            tally(CLS_OTHER_ETH, '0, '0);
            r.eth = ETH_OTHER;
        end
        r.errors = trunc_count;
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            failures++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    task automatic wait_quiet();
        while (pending_items.size() != 0 || s_tvalid) @(posedge aclk);
        while (expected_stats.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : drive
        item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_items.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                nxt = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {nxt.read_class, nxt.ip_protocol, nxt.ip_len_bytes,
                            nxt.ip_header_words, nxt.ethertype, nxt.captured_len};
                s_tuser <= nxt.func;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin : predict
        item_t it;
        if (aresetn && s_tvalid && s_tready) begin
            it = make_item(func_t'(s_tuser[0]), s_tdata[15:0], s_tdata[31:16],
                           s_tdata[35:32], s_tdata[51:36], s_tdata[59:52], s_tdata[63:60]);
            expected_stats.push_back(count_packet(it));
        end
    end

    always @(posedge aclk) begin : compare
        stats_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_stats.size() == 0) begin
                failures++;
                $display("%0t: unexpected result, expected none, actual %0h %0h", $time,
                         m_tuser, m_tdata);
            end else begin
                want = expected_stats.pop_front();
                check_field("ether_class", 64'(want.eth), 64'(m_tuser[2:0]));
                check_field("ip_class", 64'(want.ip), 64'(m_tuser[5:3]));
                check_field("read_packets", want.packets, m_tdata[63:0]);
                check_field("read_payload", want.payload, m_tdata[127:64]);
                check_field("read_total", want.total, m_tdata[191:128]);
                check_field("read_errors", want.errors, m_tdata[255:192]);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn && ((s_tvalid && s_tready) || (m_tvalid && m_tready)))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge aclk);
        $display("Verification failed");
        $finish;
    end

    initial begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
            pkt_count[c]     = '0;
            payload_count[c] = '0;
            byte_count[c]    = '0;
        end
        trunc_count = '0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        pending_items.push_back(make_item(FUNC_PACKET, 16'd0, ETYPE_IPV4, 4'd5, 16'd40,
                                          PROTO_TCP, CLS_IPV4));
        pending_items.push_back(make_item(FUNC_PACKET, ETH_HDR_BYTES - 1, 16'h1234, 4'd0,
                                          16'd0, 8'd0, CLS_IPV4));
        pending_items.push_back(make_item(FUNC_PACKET, ETH_HDR_BYTES, ETYPE_IPV6, 4'd0,
                                          16'd0, 8'd0, CLS_IPV4));
        pending_items.push_back(make_item(FUNC_PACKET, ETH_HDR_BYTES, ETYPE_IPV4, 4'd5,
                                          16'd40, PROTO_UDP, CLS_IPV4));
        pending_items.push_back(make_item(FUNC_PACKET, ETH_IPV4_HDR_BYTES - 1, ETYPE_IPV4,
                                          4'd5, 16'd40, PROTO_UDP, CLS_IPV4));
        pending_items.push_back(make_item(FUNC_PACKET, ETH_IPV4_HDR_BYTES, ETYPE_IPV4, 4'd5,
                                          16'd20, PROTO_TCP, CLS_IPV4));
        pending_items.push_back(make_item(FUNC_PACKET, 16'hFFFF, ETYPE_IPV4, 4'd0, 16'hFFFF,
                                          PROTO_ICMP, CLS_IPV4));
        pending_items.push_back(make_item(FUNC_PACKET, 16'd1500, ETYPE_IPV4, 4'hF, 16'd0,
                                          PROTO_UDP, CLS_IPV4));
        pending_items.push_back(make_item(FUNC_PACKET, 16'd60, ETYPE_IPV4, 4'hF, 16'd61,
                                          8'd0, CLS_IPV4));
        pending_items.push_back(make_item(FUNC_PACKET, 16'd60, ETYPE_IPV4, 4'd5, 16'd1500,
                                          8'hFF, CLS_IPV4));
        pending_items.push_back(make_item(FUNC_PACKET, 16'd42, ETYPE_ARP, 4'd0, 16'd0, 8'd0,
                                          CLS_IPV4));
        pending_items.push_back(make_item(FUNC_PACKET, 16'd64, 16'hFFFF, 4'hF, 16'hFFFF,
                                          8'hFF, CLS_LAST_CODE));
        pending_items.push_back(make_item(FUNC_PACKET, ETH_HDR_BYTES, 16'h0000, 4'd0, 16'd0,
                                          8'd0, CLS_IPV4));
        pending_items.push_back(make_item(FUNC_PACKET, 16'hFFFF, ETYPE_IPV6, 4'd0, 16'd0,
                                          8'd0, CLS_IPV4));
        for (int c = CLS_IPV4; c <= CLS_OTHER_IP; c++)
            pending_items.push_back(make_item(FUNC_READ, 16'd0, 16'd0, 4'd0, 16'd0, 8'd0,
                                              CLS_W'(c)));
        pending_items.push_back(make_item(FUNC_READ, 16'hFFFF, 16'hFFFF, 4'hF, 16'hFFFF,
                                          8'hFF, CLS_FIRST_UNUSED));
        pending_items.push_back(make_item(FUNC_READ, 16'd0, 16'd0, 4'd0, 16'd0, 8'd0,
                                          CLS_LAST_CODE));
        wait_quiet();

        for (int phase = 0; phase < 2; phase++) begin
            for (int n = 0; n < RANDOM_ITEMS; n++)
                pending_items.push_back(($urandom_range(99) < 75) ? random_packet()
                                                                  : random_read());
            wait_quiet();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failures == 0 && expected_stats.size() == 0) begin
            $display("Verification passed");
        end else begin
            if (expected_stats.size() != 0)
                $display("%0t: results missing, expected %0d more, actual 0", $time,
                         expected_stats.size());
            $display("Verification failed");
        end
        $finish;
    end

endmodule
